/* design/tpss_pkg.sv */
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared constants, codes, transaction types and helpers for the tick pattern
// step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tpss_pkg;

   // Sizing of the pattern store and the sequencer timing.
   localparam int PATTERN_COUNT     = 8;
   localparam int STEPS_PER_PATTERN = 16;
   localparam int TICK_INTERVAL     = 10;
   localparam int STORE_DEPTH       = PATTERN_COUNT * STEPS_PER_PATTERN;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ACT_W  = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
   localparam int STEP_W = $clog2(STEPS_PER_PATTERN + 1);

   // Fixed field widths.
   localparam int OP_W       = 3;
   localparam int PID_W      = 3;
   localparam int SIDX_W     = 4;
   localparam int DUR_W      = 8;
   localparam int CODE_W     = 2;
   localparam int WORD_W     = DUR_W + 2 * CODE_W;
   localparam int CSR_W      = 14;
   localparam int TIME_W     = DUR_W + CSR_W;
   localparam int ANGLE_W    = 8;
   localparam int CUR_STEP_W = 4;

   localparam logic [CSR_W-1:0] SIXTEENTH_MS_RESET = CSR_W'(125);

   // Actuator angles.
   localparam logic [ANGLE_W-1:0] ANGLE_STRUM_RAISED  = ANGLE_W'(0);
   localparam logic [ANGLE_W-1:0] ANGLE_STRUM_LOWERED = ANGLE_W'(180);
   localparam logic [ANGLE_W-1:0] ANGLE_MUTE_RAISED   = ANGLE_W'(29);
   localparam logic [ANGLE_W-1:0] ANGLE_MUTE_LOWERED  = ANGLE_W'(140);

   // Step action codes.
   localparam logic [CODE_W-1:0] STRUM_HIT  = 2'd1;
   localparam logic [CODE_W-1:0] STRUM_LIFT = 2'd2;
   localparam logic [CODE_W-1:0] MUTE_KEEP  = 2'd0;
   localparam logic [CODE_W-1:0] MUTE_ON    = 2'd1;
   localparam logic [CODE_W-1:0] MUTE_CLEAR = 2'd2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
   localparam logic [OP_W-1:0] OP_START   = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
   localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PID_W-1:0]  pattern_id;
      logic [SIDX_W-1:0] step_index;
      logic [DUR_W-1:0]  step_sixteenths;
      logic [CODE_W-1:0] strum_code;
      logic [CODE_W-1:0] mute_code;
      logic              last_step;
      logic              loop_mode;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]    strum_angle;
      logic [ANGLE_W-1:0]    mute_angle;
      logic                  strum_moved;
      logic                  mute_moved;
      logic                  running;
      logic [CUR_STEP_W-1:0] current_step;
   } rsp_type;

   // Transaction held in the execute stage, decoded at issue.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             pid_ok;
      logic [ACT_W-1:0] active;
      logic             loop_mode;
      logic             wrap;
   } item_type;

   // Play position as it stands after all older transactions.
   typedef struct packed {
      logic [ACT_W-1:0]  active;
      logic [STEP_W-1:0] step;
   } play_pos_type;

   // Store address of one step of one pattern.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [ACT_W-1:0] pat,
                                                    input logic [STEP_W-1:0] step);
      int sum;
      sum = int'(pat) * STEPS_PER_PATTERN + int'(step);
      return ADDR_W'(sum);
   endfunction

endpackage

`default_nettype wire

/* design/tpss_store.sv */
// ----------------------------------------------------------------------------
// tpss_store
// Pattern step memory: one write port and one read port, registered read data,
// and a clearing sweep after reset that zeroes every entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_store
   import tpss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data,
   output logic                   busy
);

   logic [WORD_W-1:0] mem [STORE_DEPTH];
   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;
   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] rd_data_ff;

   // The sweep walks the store once, one entry per cycle.
   always_comb begin
      clr_idx_in = clr_idx_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_idx_ff <= clr_idx_in;
         busy_ff    <= busy_in;
      end
   end

   // Memory array: the sweep has priority over normal writes.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

/* design/tpss_play.sv */
// ----------------------------------------------------------------------------
// tpss_play
// Playback state and execute stage: applies one transaction against the
// step word read from the store and forms its response.
// ----------------------------------------------------------------------------
`default_nettype none

module tpss_play
   import tpss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire logic              item_fire,
   input  wire item_type          item,
   input  wire logic [WORD_W-1:0] word,
   input  wire logic [CSR_W-1:0]  sixteenth_ms,
   output play_pos_type           fwd_pos,
   output rsp_type                result
);

   logic [ACT_W-1:0]  active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] time_left_ff, time_left_in;
   logic              playing_ff, playing_in;
   logic              repeat_ff, repeat_in;
   logic [CODE_W-1:0] mute_status_ff, mute_status_in;
   logic              strum_lowered_ff, strum_lowered_in;
   logic              mute_lowered_ff, mute_lowered_in;

   logic              strum_moved;
   logic              mute_moved;
   logic              load;
   logic [STEP_W-1:0] next_step;
   logic [DUR_W-1:0]  word_dur;
   logic [CODE_W-1:0] word_strum;
   logic [CODE_W-1:0] word_mute;
   logic [TIME_W-1:0] step_time;

   assign word_dur   = word[WORD_W-1 -: DUR_W];
   assign word_strum = word[2*CODE_W-1 -: CODE_W];
   assign word_mute  = word[CODE_W-1:0];
   assign next_step  = step_ff + 1'b1;

   // Countdown of a freshly loaded step.
   assign step_time = {{CSR_W{1'b0}}, word_dur} * {{DUR_W{1'b0}}, sixteenth_ms};

   // Next playback state for the transaction in this stage.
   always_comb begin
      active_in        = active_ff;
      step_in          = step_ff;
      time_left_in     = time_left_ff;
      playing_in       = playing_ff;
      repeat_in        = repeat_ff;
      mute_status_in   = mute_status_ff;
      strum_lowered_in = strum_lowered_ff;
      mute_lowered_in  = mute_lowered_ff;
      strum_moved      = 1'b0;
      mute_moved       = 1'b0;
      load             = 1'b0;

      case (item.op)
         OP_TICK: begin
            if (playing_ff) begin
               if (time_left_ff > TIME_W'(TICK_INTERVAL)) begin
                  time_left_in = time_left_ff - TIME_W'(TICK_INTERVAL);
               end else if (item.wrap) begin
                  if (repeat_ff) begin
                     step_in = '0;
                     load    = 1'b1;
                  end else begin
                     playing_in = 1'b0;
                     step_in    = next_step;
                  end
               end else begin
                  step_in = next_step;
                  load    = 1'b1;
               end
            end
         end
         OP_START: begin
            if (item.pid_ok) begin
               active_in  = item.active;
               step_in    = '0;
               load       = 1'b1;
               repeat_in  = item.loop_mode;
               playing_in = 1'b1;
            end
         end
         OP_RESTART: begin
            playing_in = 1'b1;
            step_in    = '0;
            load       = 1'b1;
         end
         OP_STOP: begin
            playing_in       = 1'b0;
            time_left_in     = '0;
            repeat_in        = 1'b0;
            strum_lowered_in = 1'b0;
            mute_lowered_in  = 1'b0;
            strum_moved      = 1'b1;
            mute_moved       = 1'b1;
         end
         OP_TOGGLE: begin
            if (mute_status_ff == MUTE_ON) begin
               mute_status_in  = MUTE_CLEAR;
               mute_lowered_in = 1'b0;
            end else begin
               mute_status_in  = MUTE_ON;
               mute_lowered_in = 1'b1;
            end
            mute_moved = 1'b1;
         end
         default: begin
         end
      endcase

      // Apply the step word read for this transaction.
      if (load) begin
         time_left_in   = step_time;
         mute_status_in = word_mute;
         case (word_strum)
            STRUM_HIT: begin
               strum_lowered_in = 1'b1;
               strum_moved      = 1'b1;
            end
            STRUM_LIFT: begin
               strum_lowered_in = 1'b0;
               strum_moved      = 1'b1;
            end
            default: begin
            end
         endcase
         case (word_mute)
            MUTE_ON: begin
               mute_lowered_in = 1'b1;
               mute_moved      = 1'b1;
            end
            MUTE_CLEAR: begin
               mute_lowered_in = 1'b0;
               mute_moved      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= '0;
         step_ff          <= '0;
         time_left_ff     <= '0;
         playing_ff       <= 1'b0;
         repeat_ff        <= 1'b0;
         mute_status_ff   <= MUTE_KEEP;
         strum_lowered_ff <= 1'b0;
         mute_lowered_ff  <= 1'b0;
      end else if (item_fire) begin
         active_ff        <= active_in;
         step_ff          <= step_in;
         time_left_ff     <= time_left_in;
         playing_ff       <= playing_in;
         repeat_ff        <= repeat_in;
         mute_status_ff   <= mute_status_in;
         strum_lowered_ff <= strum_lowered_in;
         mute_lowered_ff  <= mute_lowered_in;
      end
   end

   // Position seen by the issue stage includes the transaction held here.
   always_comb begin
      if (item_valid) begin
         fwd_pos.active = active_in;
         fwd_pos.step   = step_in;
      end else begin
         fwd_pos.active = active_ff;
         fwd_pos.step   = step_ff;
      end
   end

   // Response for this transaction.
   always_comb begin
      result.strum_angle  = strum_lowered_in ? ANGLE_STRUM_LOWERED : ANGLE_STRUM_RAISED;
      result.mute_angle   = mute_lowered_in ? ANGLE_MUTE_LOWERED : ANGLE_MUTE_RAISED;
      result.strum_moved  = strum_moved;
      result.mute_moved   = mute_moved;
      result.running      = playing_in;
      result.current_step = CUR_STEP_W'(step_in);
   end

endmodule

`default_nettype wire

/* design/tick_pattern_step_sequencer_top.sv */
// ----------------------------------------------------------------------------
// tick_pattern_step_sequencer_top
// Tick-driven step sequencer that plays stored patterns to a strum and a
// mute actuator and reports their angles for every transaction.
// ----------------------------------------------------------------------------
//   Channel   Ports                       Direction  Content
//   request   req_valid/ready/data        in         one command (req_type)
//   response  rsp_valid/ready/data        out        one response (rsp_type)
//   csr       csr_wr_en/csr_wr_data       in         sixteenth_ms, no wait
//
// One transaction per cycle is accepted unless a stall holds it. A request is
// decoded and issues its store access in the cycle it is accepted, is then held
// in the execute stage register, and its response is held in the output register.
// After reset the store is cleared one entry per cycle; req_ready stays low
// during that sweep, csr writes are taken as usual.
// A stalled response holds the execute stage and then the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_pattern_step_sequencer_top
   import tpss_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   logic [CSR_W-1:0]  sixteenth_ms_ff;
   logic [STEP_W-1:0] lengths_ff [PATTERN_COUNT];

   logic              ex_valid_ff, ex_valid_in;
   item_type          ex_item_ff, ex_item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              ex_advance;
   logic              ex_fire;
   logic              pid_ok;
   logic              sidx_ok;
   logic [ACT_W-1:0]  req_pat;
   logic [STEP_W-1:0] req_step;
   play_pos_type      fwd_pos;
   logic [STEP_W-1:0] iss_len;
   logic [STEP_W-1:0] iss_next;
   logic              iss_wrap;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              store_busy;
   rsp_type           ex_result;

   // Handshake: the execute stage moves on when the output register frees up.
   assign ex_advance = !rsp_valid_ff || rsp_ready;
   assign ex_fire    = ex_valid_ff && ex_advance;
   assign req_ready  = !store_busy && (!ex_valid_ff || ex_advance);
   assign accept     = req_valid && req_ready;

   // Request decode.
   assign pid_ok   = int'(req_data.pattern_id) < PATTERN_COUNT;
   assign sidx_ok  = int'(req_data.step_index) < STEPS_PER_PATTERN;
   assign req_pat  = ACT_W'(req_data.pattern_id);
   assign req_step = STEP_W'(req_data.step_index);

   // Step that a tick would move to, from the position after older transactions.
   assign iss_len  = lengths_ff[fwd_pos.active];
   assign iss_next = fwd_pos.step + 1'b1;
   assign iss_wrap = iss_next >= iss_len;

   // Store access issued with the request.
   always_comb begin
      case (req_data.op)
         OP_START:   rd_addr = store_addr(req_pat, '0);
         OP_RESTART: rd_addr = store_addr(fwd_pos.active, '0);
         default:    rd_addr = store_addr(fwd_pos.active, iss_wrap ? '0 : iss_next);
      endcase
   end

   assign rd_en   = accept && (req_data.op == OP_TICK || req_data.op == OP_START ||
                               req_data.op == OP_RESTART);
   assign wr_en   = accept && (req_data.op == OP_WRITE) && pid_ok && sidx_ok;
   assign wr_addr = store_addr(req_pat, req_step);
   assign wr_data = {req_data.step_sixteenths, req_data.strum_code, req_data.mute_code};

   tpss_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   // Pattern lengths are set by a step write that carries the last-step flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_COUNT; i++) begin
            lengths_ff[i] <= '0;
         end
      end else if (wr_en && req_data.last_step) begin
         lengths_ff[req_pat] <= req_step + 1'b1;
      end
   end

   // Tempo register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sixteenth_ms_ff <= SIXTEENTH_MS_RESET;
      end else if (csr_wr_en) begin
         sixteenth_ms_ff <= csr_wr_data;
      end
   end

   // Execute stage register.
   always_comb begin
      ex_item_in.op        = req_data.op;
      ex_item_in.pid_ok    = pid_ok;
      ex_item_in.active    = req_pat;
      ex_item_in.loop_mode = req_data.loop_mode;
      ex_item_in.wrap      = iss_wrap;
      if (accept) begin
         ex_valid_in = 1'b1;
      end else if (ex_fire) begin
         ex_valid_in = 1'b0;
      end else begin
         ex_valid_in = ex_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_item_ff <= ex_item_in;
      end
   end

   tpss_play u_play (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (ex_valid_ff),
      .item_fire    (ex_fire),
      .item         (ex_item_ff),
      .word         (rd_data),
      .sixteenth_ms (sixteenth_ms_ff),
      .fwd_pos      (fwd_pos),
      .result       (ex_result)
   );

   // Output register.
   always_comb begin
      if (ex_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_data_ff <= ex_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
